>>> rtl/wws_pkg.sv
`timescale 1ns / 1ps

package wws_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_RUN        = 3'd1,
      MODE_LOW        = 3'd2,
      MODE_DISABLE    = 3'd3,
      MODE_WD_DISABLE = 3'd4
   } wws_mode_type;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_KICK     = 3'd1,
      OP_CHANGE   = 3'd2,
      OP_WD_MODE  = 3'd3,
      OP_ACTIVITY = 3'd4
   } wws_op_type;

   typedef enum logic [2:0] {
      REG_WINDOW_LOW       = 3'd0,
      REG_WINDOW_HIGH      = 3'd1,
      REG_INVALID_LIMIT    = 3'd2,
      REG_SECOND_PERIOD    = 3'd3,
      REG_REGULATION_EN    = 3'd4,
      REG_INACTIVITY_EN    = 3'd5,
      REG_INACTIVITY_LIMIT = 3'd6
   } wws_reg_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [2:0] target_state;
      logic       watchdog_mode;
   } wws_req_type;

   typedef struct packed {
      logic [2:0] system_state;
      logic       encoders_enabled;
      logic       brake_pulse;
      logic       kick_taken;
      logic       battery_sample;
      logic       regulation_pulse;
      logic       battery_clear;
      logic       shutdown;
   } wws_rsp_type;

   typedef struct packed {
      logic [15:0] window_low_ms;
      logic [15:0] window_high_ms;
      logic [7:0]  invalid_limit;
      logic [15:0] second_period_ms;
      logic        regulation_enable;
      logic        inactivity_enable;
      logic [19:0] inactivity_limit_ms;
   } wws_cfg_type;

   localparam int          CSR_ADDR_W         = 5;
   localparam int          CSR_DATA_W         = 32;

   localparam logic [15:0] WINDOW_LOW_RESET   = 16'd970;
   localparam logic [15:0] WINDOW_HIGH_RESET  = 16'd1030;
   localparam logic [7:0]  INVALID_LIM_RESET  = 8'd3;
   localparam logic [15:0] PERIOD_RESET       = 16'd1000;
   localparam logic [19:0] INACT_LIMIT_RESET  = 20'd120000;

   localparam logic [15:0] TICK_STEP          = 16'd10;
   localparam logic [15:0] OVERRUN_RELOAD     = 16'd30;
   localparam logic [7:0]  INVALID_MAX        = 8'hFF;
   localparam logic [19:0] INACT_MAX          = 20'hFFFFF;

   // tick_ms wraps modulo 2^16; remainder of 2^16 by the period
   localparam logic [16:0] WRAP_DIVIDEND      = 17'h10000;
   localparam logic [15:0] WRAP_REM_RESET     = 16'(65536 % 1000);
   localparam logic [4:0]  MOD_LAST_BIT       = 5'd16;

   // x % 500 == 0 <=> x % 4 == 0 and (x / 4) * inv(125) mod 2^14 <= (2^14 - 1) / 125
   localparam int          SAMPLE_ODD         = 125;
   localparam logic [13:0] SAMPLE_INV         = 14'd14549;
   localparam logic [13:0] SAMPLE_LIMIT       = 14'((2 ** 14 - 1) / SAMPLE_ODD);

   function automatic logic [3:0] small_mod(logic [4:0] val, logic [3:0] div);
      logic [4:0] rem;
      rem = 5'd0;
      for (int i = 4; i >= 0; i--) begin
         rem = {rem[3:0], val[i]};
         if (rem >= {1'b0, div}) begin
            rem = rem - {1'b0, div};
         end
      end
      return rem[3:0];
   endfunction

endpackage

>>> rtl/windowed_watchdog_supervisor_unit.sv
`timescale 1ns / 1ps

// Robot supervisor with a windowed watchdog and a five-state mode machine. Each request
// word carries one operation (tick, kick, state change, watchdog mode, activity) and
// yields exactly one response word. A word is taken every cycle that req_stall is low: it
// lands in an input register and its response is then registered in the output register.
// While a response is stalled, one more request can still wait in the input register;
// further requests then stall. Writing second_period_ms starts a bit-serial remainder
// unit that then loads its result; req_stall is high from the write cycle until that load.
// Other register writes take effect at once. After an inactivity shutdown every request
// is answered with the frozen state and shutdown set.
module windowed_watchdog_supervisor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wws_pkg::wws_req_type            req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wws_pkg::wws_rsp_type            rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wws_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wws_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wws_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   wws_pkg::wws_cfg_type cfg;
   wws_pkg::wws_req_type s1_word_ff;
   wws_pkg::wws_rsp_type rsp_word_ff;
   wws_pkg::wws_rsp_type result;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 period_wr;
   logic                 mod_busy;
   logic                 mod_done;
   logic [15:0]          mod_tick_rem;
   logic [15:0]          mod_wrap_rem;
   logic [15:0]          tick_ms;
   logic                 advance;
   logic                 req_take;

   wws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg),
      .period_wr   (period_wr)
   );

   wws_modulo u_modulo (
      .clock    (clock),
      .reset    (reset),
      .start    (period_wr),
      .period   (cfg.second_period_ms),
      .dividend (tick_ms),
      .busy     (mod_busy),
      .done     (mod_done),
      .tick_rem (mod_tick_rem),
      .wrap_rem (mod_wrap_rem)
   );

   wws_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (s1_word_ff),
      .cfg           (cfg),
      .load          (mod_done),
      .load_tick_rem (mod_tick_rem),
      .load_wrap_rem (mod_wrap_rem),
      .tick_ms       (tick_ms),
      .result        (result)
   );

   assign advance      = s1_valid_ff && !mod_busy && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = mod_busy || period_wr || (s1_valid_ff && !advance);
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign csr_pready = 1'b1;

endmodule

>>> rtl/wws_csr.sv
`timescale 1ns / 1ps

module wws_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wws_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wws_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wws_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output wws_pkg::wws_cfg_type            cfg,
   output logic                            period_wr
);

   wws_pkg::wws_cfg_type cfg_ff;
   wws_pkg::wws_cfg_type cfg_in;
   wws_pkg::wws_reg_type reg_sel;
   logic                 wr_en;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = wws_pkg::wws_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in    = cfg_ff;
      period_wr = 1'b0;
      if (wr_en) begin
         unique case (reg_sel)
            wws_pkg::REG_WINDOW_LOW:       cfg_in.window_low_ms = csr_pwdata[15:0];
            wws_pkg::REG_WINDOW_HIGH:      cfg_in.window_high_ms = csr_pwdata[15:0];
            wws_pkg::REG_INVALID_LIMIT:    cfg_in.invalid_limit = csr_pwdata[7:0];
            wws_pkg::REG_SECOND_PERIOD: begin
               cfg_in.second_period_ms = csr_pwdata[15:0];
               period_wr               = 1'b1;
            end
            wws_pkg::REG_REGULATION_EN:    cfg_in.regulation_enable = csr_pwdata[0];
            wws_pkg::REG_INACTIVITY_EN:    cfg_in.inactivity_enable = csr_pwdata[0];
            wws_pkg::REG_INACTIVITY_LIMIT: cfg_in.inactivity_limit_ms = csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         wws_pkg::REG_WINDOW_LOW:       csr_prdata = 32'(cfg_ff.window_low_ms);
         wws_pkg::REG_WINDOW_HIGH:      csr_prdata = 32'(cfg_ff.window_high_ms);
         wws_pkg::REG_INVALID_LIMIT:    csr_prdata = 32'(cfg_ff.invalid_limit);
         wws_pkg::REG_SECOND_PERIOD:    csr_prdata = 32'(cfg_ff.second_period_ms);
         wws_pkg::REG_REGULATION_EN:    csr_prdata = 32'(cfg_ff.regulation_enable);
         wws_pkg::REG_INACTIVITY_EN:    csr_prdata = 32'(cfg_ff.inactivity_enable);
         wws_pkg::REG_INACTIVITY_LIMIT: csr_prdata = 32'(cfg_ff.inactivity_limit_ms);
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low_ms       <= wws_pkg::WINDOW_LOW_RESET;
         cfg_ff.window_high_ms      <= wws_pkg::WINDOW_HIGH_RESET;
         cfg_ff.invalid_limit       <= wws_pkg::INVALID_LIM_RESET;
         cfg_ff.second_period_ms    <= wws_pkg::PERIOD_RESET;
         cfg_ff.regulation_enable   <= 1'b0;
         cfg_ff.inactivity_enable   <= 1'b1;
         cfg_ff.inactivity_limit_ms <= wws_pkg::INACT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/wws_modulo.sv
`timescale 1ns / 1ps

module wws_modulo (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] period,
   input  logic [15:0] dividend,
   output logic        busy,
   output logic        done,
   output logic [15:0] tick_rem,
   output logic [15:0] wrap_rem
);

   logic        active_ff;
   logic        active_in;
   logic        done_ff;
   logic        done_in;
   logic [4:0]  idx_ff;
   logic [4:0]  idx_in;
   logic [15:0] trem_ff;
   logic [15:0] trem_in;
   logic [15:0] wrem_ff;
   logic [15:0] wrem_in;

   logic [16:0] tick_dividend;
   logic [16:0] divisor;
   logic [16:0] tshift;
   logic [16:0] wshift;
   logic [16:0] ttrial;
   logic [16:0] wtrial;

   assign tick_dividend = {1'b0, dividend};
   assign divisor       = {1'b0, period};
   assign tshift        = {trem_ff, tick_dividend[idx_ff]};
   assign wshift        = {wrem_ff, wws_pkg::WRAP_DIVIDEND[idx_ff]};
   assign ttrial        = tshift - divisor;
   assign wtrial        = wshift - divisor;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      idx_in    = idx_ff;
      trem_in   = trem_ff;
      wrem_in   = wrem_ff;
      if (start) begin
         active_in = 1'b1;
         idx_in    = wws_pkg::MOD_LAST_BIT;
         trem_in   = '0;
         wrem_in   = '0;
      end else if (active_ff) begin
         trem_in = (tshift >= divisor) ? ttrial[15:0] : tshift[15:0];
         wrem_in = (wshift >= divisor) ? wtrial[15:0] : wshift[15:0];
         if (idx_ff == 5'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            idx_in = idx_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      trem_ff <= trem_in;
      wrem_ff <= wrem_in;
   end

   assign busy     = active_ff || done_ff;
   assign done     = done_ff;
   assign tick_rem = trem_ff;
   assign wrap_rem = wrem_ff;

endmodule

>>> rtl/wws_core.sv
`timescale 1ns / 1ps

module wws_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  wws_pkg::wws_req_type item,
   input  wws_pkg::wws_cfg_type cfg,
   input  logic                 load,
   input  logic [15:0]          load_tick_rem,
   input  logic [15:0]          load_wrap_rem,
   output logic [15:0]          tick_ms,
   output wws_pkg::wws_rsp_type result
);

   wws_pkg::wws_mode_type mode_ff, mode_pre, mode_in;
   logic        running_ff, running_pre, running_in;
   logic [15:0] wd_ff, wd_pre, wd_in;
   logic [7:0]  invalid_ff, invalid_pre, invalid_in;
   logic [15:0] tick_ff, tick_pre, tick_in;
   logic [15:0] tick_rem_ff, tick_rem_pre, tick_rem_in;
   logic [15:0] wrap_rem_ff, wrap_rem_in;
   logic [19:0] inact_ff, inact_pre, inact_in;
   logic        halted_ff, halted_in;
   logic        enc_ff, enc_pre, enc_in;

   logic        enter_en;
   logic [2:0]  enter_tgt;
   logic        kick_pulse;
   logic        sample_pulse;
   logic        reg_pulse;
   logic        brake_pulse;
   logic        clear_pulse;

   logic [15:0] period;
   logic [16:0] tick_sum;
   logic [16:0] rem_base;
   logic [3:0]  rem_small;
   logic [16:0] rem_trial;
   logic [15:0] rem_step;
   logic        period_hit;
   logic [16:0] wrap_fix;
   logic [15:0] rem_wrapped;
   logic [15:0] tick_next;
   logic [15:0] tick_rem_next;
   logic [13:0] sample_prod;
   logic        sample_hit;
   logic [16:0] wd_sum;
   logic [15:0] wd_sat;
   logic [15:0] wd_tick;
   logic        wd_over;
   logic [7:0]  invalid_inc;
   logic [7:0]  tick_invalid;
   logic        in_window;
   logic [20:0] inact_sum;
   logic [19:0] inact_sat;

   assign period        = cfg.second_period_ms;
   assign tick_sum      = {1'b0, tick_ff} + {1'b0, wws_pkg::TICK_STEP};
   assign rem_base      = {1'b0, tick_rem_ff} + {1'b0, wws_pkg::TICK_STEP};
   assign rem_small     = wws_pkg::small_mod(rem_base[4:0], period[3:0]);
   assign rem_trial     = rem_base - {1'b0, period};
   assign rem_step      = (period[15:4] == 12'd0) ? {12'd0, rem_small} :
                          ((rem_base >= {1'b0, period}) ? rem_trial[15:0] : rem_base[15:0]);
   assign period_hit    = (period != 16'd0) && (rem_step == 16'd0);
   assign wrap_fix      = {1'b0, rem_step} + {1'b0, period} - {1'b0, wrap_rem_ff};
   assign rem_wrapped   = (rem_step >= wrap_rem_ff) ? (rem_step - wrap_rem_ff) : wrap_fix[15:0];
   assign tick_next     = period_hit ? 16'd0 : tick_sum[15:0];
   assign tick_rem_next = period_hit ? 16'd0 : (tick_sum[16] ? rem_wrapped : rem_step);

   assign sample_prod   = 14'(tick_next[15:2] * wws_pkg::SAMPLE_INV);
   assign sample_hit    = (tick_next[1:0] == 2'd0) && (sample_prod <= wws_pkg::SAMPLE_LIMIT);

   assign wd_sum        = {1'b0, wd_ff} + {1'b0, wws_pkg::TICK_STEP};
   assign wd_sat        = wd_sum[16] ? 16'hFFFF : wd_sum[15:0];
   assign wd_tick       = (running_ff && (mode_ff != wws_pkg::MODE_IDLE)) ? wd_sat : 16'd0;
   assign wd_over       = wd_tick > cfg.window_high_ms;
   assign invalid_inc   = (invalid_ff != wws_pkg::INVALID_MAX) ? (invalid_ff + 8'd1) : invalid_ff;
   assign tick_invalid  = wd_over ? invalid_inc : invalid_ff;
   assign in_window     = (wd_ff >= cfg.window_low_ms) && (wd_ff <= cfg.window_high_ms);
   assign inact_sum     = {1'b0, inact_ff} + 21'(wws_pkg::TICK_STEP);
   assign inact_sat     = inact_sum[20] ? wws_pkg::INACT_MAX : inact_sum[19:0];

   always_comb begin
      mode_pre     = mode_ff;
      running_pre  = running_ff;
      wd_pre       = wd_ff;
      invalid_pre  = invalid_ff;
      tick_pre     = tick_ff;
      tick_rem_pre = load ? load_tick_rem : tick_rem_ff;
      wrap_rem_in  = load ? load_wrap_rem : wrap_rem_ff;
      inact_pre    = inact_ff;
      enc_pre      = enc_ff;
      halted_in    = halted_ff;
      enter_en     = 1'b0;
      enter_tgt    = wws_pkg::MODE_WD_DISABLE;
      kick_pulse   = 1'b0;
      sample_pulse = 1'b0;
      reg_pulse    = 1'b0;
      if (step && !halted_ff) begin
         unique case (wws_pkg::wws_op_type'(item.operation))
            wws_pkg::OP_TICK: begin
               tick_pre     = tick_next;
               tick_rem_pre = tick_rem_next;
               inact_pre    = inact_sat;
               reg_pulse    = cfg.regulation_enable;
               wd_pre       = wd_over ? wws_pkg::OVERRUN_RELOAD : wd_tick;
               invalid_pre  = tick_invalid;
               if (tick_invalid > cfg.invalid_limit) begin
                  enter_en = 1'b1;
               end
               sample_pulse = sample_hit;
               halted_in    = cfg.inactivity_enable && (inact_sat >= cfg.inactivity_limit_ms);
            end
            wws_pkg::OP_KICK: begin
               if (((mode_ff == wws_pkg::MODE_RUN) || (mode_ff == wws_pkg::MODE_LOW))
                   && running_ff) begin
                  if (in_window) begin
                     invalid_pre = 8'd0;
                  end else begin
                     invalid_pre = invalid_inc;
                     if (invalid_inc > cfg.invalid_limit) begin
                        enter_en = 1'b1;
                     end
                  end
                  wd_pre     = 16'd0;
                  kick_pulse = 1'b1;
               end
            end
            wws_pkg::OP_CHANGE: begin
               enter_en  = 1'b1;
               enter_tgt = item.target_state;
            end
            wws_pkg::OP_WD_MODE: begin
               running_pre = item.watchdog_mode;
            end
            wws_pkg::OP_ACTIVITY: begin
               inact_pre = 20'd0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in     = mode_pre;
      running_in  = running_pre;
      wd_in       = wd_pre;
      invalid_in  = invalid_pre;
      tick_in     = tick_pre;
      tick_rem_in = tick_rem_pre;
      inact_in    = inact_pre;
      enc_in      = enc_pre;
      brake_pulse = 1'b0;
      clear_pulse = 1'b0;
      if (enter_en) begin
         unique case (enter_tgt)
            wws_pkg::MODE_IDLE: begin
               mode_in     = wws_pkg::MODE_IDLE;
               running_in  = 1'b0;
               wd_in       = 16'd0;
               invalid_in  = 8'd0;
               tick_in     = 16'd0;
               tick_rem_in = 16'd0;
               enc_in      = 1'b0;
               brake_pulse = 1'b1;
            end
            wws_pkg::MODE_RUN, wws_pkg::MODE_LOW: begin
               mode_in = wws_pkg::wws_mode_type'(enter_tgt);
               enc_in  = 1'b1;
               wd_in   = 16'd0;
            end
            wws_pkg::MODE_WD_DISABLE: begin
               mode_in     = wws_pkg::MODE_WD_DISABLE;
               enc_in      = 1'b0;
               brake_pulse = 1'b1;
               running_in  = 1'b0;
            end
            default: begin
               mode_in     = wws_pkg::MODE_DISABLE;
               enc_in      = 1'b0;
               brake_pulse = 1'b1;
               running_in  = 1'b0;
               clear_pulse = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      result.system_state     = mode_in;
      result.encoders_enabled = enc_in;
      result.brake_pulse      = brake_pulse;
      result.kick_taken       = kick_pulse;
      result.battery_sample   = sample_pulse;
      result.regulation_pulse = reg_pulse;
      result.battery_clear    = clear_pulse;
      result.shutdown         = halted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= wws_pkg::MODE_IDLE;
         running_ff  <= 1'b0;
         wd_ff       <= '0;
         invalid_ff  <= '0;
         tick_ff     <= '0;
         tick_rem_ff <= '0;
         wrap_rem_ff <= wws_pkg::WRAP_REM_RESET;
         inact_ff    <= '0;
         halted_ff   <= 1'b0;
         enc_ff      <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         running_ff  <= running_in;
         wd_ff       <= wd_in;
         invalid_ff  <= invalid_in;
         tick_ff     <= tick_in;
         tick_rem_ff <= tick_rem_in;
         wrap_rem_ff <= wrap_rem_in;
         inact_ff    <= inact_in;
         halted_ff   <= halted_in;
         enc_ff      <= enc_in;
      end
   end

   assign tick_ms = tick_ff;

endmodule

>>> bench/wws_response_checker.sv
`timescale 1ns / 1ps

module wws_response_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  wws_pkg::wws_req_type            req_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  wws_pkg::wws_rsp_type            rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wws_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wws_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                            csr_pready,
   output int unsigned                     mismatch_count,
   output int unsigned                     words_outstanding
);

   localparam int unsigned SAMPLE_PERIOD_MS = 500;
   localparam logic [15:0] WD_COUNT_CEIL    = 16'hFFFF;

   logic [15:0]  win_lo;
   logic [15:0]  win_hi;
   logic [7:0]   kick_limit;
   logic [15:0]  period_ms;
   logic         reg_en;
   logic         idle_en;
   logic [19:0]  idle_limit;

   wws_pkg::wws_mode_type mode_q;
   logic         wd_run;
   logic [15:0]  wd_ms;
   logic [7:0]   bad_kicks;
   logic [15:0]  sec_ms;
   logic [19:0]  idle_ms;
   logic         halted_q;
   logic         enc_on;
   logic         brake_now;
   logic         clear_now;

   wws_pkg::wws_rsp_type expected_words[$];

   function automatic void enter_mode(input logic [2:0] target);
      case (target)
         wws_pkg::MODE_IDLE: begin
            mode_q    = wws_pkg::MODE_IDLE;
            wd_run    = 1'b0;
            wd_ms     = '0;
            bad_kicks = '0;
            sec_ms    = '0;
            enc_on    = 1'b0;
            brake_now = 1'b1;
         end
         wws_pkg::MODE_RUN, wws_pkg::MODE_LOW: begin
            mode_q = wws_pkg::wws_mode_type'(target);
            enc_on = 1'b1;
            wd_ms  = '0;
         end
         wws_pkg::MODE_WD_DISABLE: begin
            mode_q    = wws_pkg::MODE_WD_DISABLE;
            enc_on    = 1'b0;
            brake_now = 1'b1;
            wd_run    = 1'b0;
         end
         default: begin
            mode_q    = wws_pkg::MODE_DISABLE;
            enc_on    = 1'b0;
            brake_now = 1'b1;
            wd_run    = 1'b0;
            clear_now = 1'b1;
         end
      endcase
   endfunction

   function automatic void count_bad_kick();
      if (bad_kicks != wws_pkg::INVALID_MAX) begin
         bad_kicks = bad_kicks + 8'd1;
      end
   endfunction

   function automatic wws_pkg::wws_rsp_type supervise_word(input wws_pkg::wws_req_type w);
      int unsigned acc;
      logic        kick;
      logic        sample;
      logic        reg_p;
      wws_pkg::wws_rsp_type r;
      kick      = 1'b0;
      sample    = 1'b0;
      reg_p     = 1'b0;
      brake_now = 1'b0;
      clear_now = 1'b0;
      if (!halted_q) begin
         case (w.operation)
            wws_pkg::OP_TICK: begin
               acc = 32'(sec_ms) + 32'(wws_pkg::TICK_STEP);
               if (period_ms != 16'd0 && (acc % 32'(period_ms)) == 0) begin
                  acc = 0;
               end
               sec_ms = acc[15:0];
               acc = 32'(idle_ms) + 32'(wws_pkg::TICK_STEP);
               idle_ms = (acc > 32'(wws_pkg::INACT_MAX)) ? wws_pkg::INACT_MAX : acc[19:0];
               reg_p = reg_en;
               if (wd_run && mode_q != wws_pkg::MODE_IDLE) begin
                  acc = 32'(wd_ms) + 32'(wws_pkg::TICK_STEP);
                  wd_ms = (acc > 32'(WD_COUNT_CEIL)) ? WD_COUNT_CEIL : acc[15:0];
               end else begin
                  wd_ms = '0;
               end
               if (wd_ms > win_hi) begin
                  wd_ms = wws_pkg::OVERRUN_RELOAD;
                  count_bad_kick();
               end
               if (bad_kicks > kick_limit) begin
                  enter_mode(wws_pkg::MODE_WD_DISABLE);
               end
               if ((32'(sec_ms) % SAMPLE_PERIOD_MS) == 0) begin
                  sample = 1'b1;
               end
               if (idle_en && idle_ms >= idle_limit) begin
                  halted_q = 1'b1;
               end
            end
            wws_pkg::OP_KICK: begin
               if ((mode_q == wws_pkg::MODE_RUN || mode_q == wws_pkg::MODE_LOW) && wd_run) begin
                  if (wd_ms >= win_lo && wd_ms <= win_hi) begin
                     bad_kicks = '0;
                  end else begin
                     count_bad_kick();
                     if (bad_kicks > kick_limit) begin
                        enter_mode(wws_pkg::MODE_WD_DISABLE);
                     end
                  end
                  wd_ms = '0;
                  kick  = 1'b1;
               end
            end
            wws_pkg::OP_CHANGE:   enter_mode(w.target_state);
            wws_pkg::OP_WD_MODE:  wd_run = w.watchdog_mode;
            wws_pkg::OP_ACTIVITY: idle_ms = '0;
            default: ;
         endcase
      end
      r.system_state     = mode_q;
      r.encoders_enabled = enc_on;
      r.brake_pulse      = brake_now;
      r.kick_taken       = kick;
      r.battery_sample   = sample;
      r.regulation_pulse = reg_p;
      r.battery_clear    = clear_now;
      r.shutdown         = halted_q;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [2:0] want,
                                input logic [2:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      wws_pkg::wws_rsp_type want;
      if (reset) begin
         win_lo     = wws_pkg::WINDOW_LOW_RESET;
         win_hi     = wws_pkg::WINDOW_HIGH_RESET;
         kick_limit = wws_pkg::INVALID_LIM_RESET;
         period_ms  = wws_pkg::PERIOD_RESET;
         reg_en     = 1'b0;
         idle_en    = 1'b1;
         idle_limit = wws_pkg::INACT_LIMIT_RESET;
         mode_q     = wws_pkg::MODE_IDLE;
         wd_run     = 1'b0;
         wd_ms      = '0;
         bad_kicks  = '0;
         sec_ms     = '0;
         idle_ms    = '0;
         halted_q   = 1'b0;
         enc_on     = 1'b0;
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t ns: response word %h with no request outstanding",
                        $time, rsp_word);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               compare_field("system_state", want.system_state, rsp_word.system_state);
               compare_field("encoders_enabled", 3'(want.encoders_enabled),
                             3'(rsp_word.encoders_enabled));
               compare_field("brake_pulse", 3'(want.brake_pulse),
                             3'(rsp_word.brake_pulse));
               compare_field("kick_taken", 3'(want.kick_taken), 3'(rsp_word.kick_taken));
               compare_field("battery_sample", 3'(want.battery_sample),
                             3'(rsp_word.battery_sample));
               compare_field("regulation_pulse", 3'(want.regulation_pulse),
                             3'(rsp_word.regulation_pulse));
               compare_field("battery_clear", 3'(want.battery_clear),
                             3'(rsp_word.battery_clear));
               compare_field("shutdown", 3'(want.shutdown), 3'(rsp_word.shutdown));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[wws_pkg::CSR_ADDR_W-1:2])
               wws_pkg::REG_WINDOW_LOW:       win_lo     = csr_pwdata[15:0];
               wws_pkg::REG_WINDOW_HIGH:      win_hi     = csr_pwdata[15:0];
               wws_pkg::REG_INVALID_LIMIT:    kick_limit = csr_pwdata[7:0];
               wws_pkg::REG_SECOND_PERIOD:    period_ms  = csr_pwdata[15:0];
               wws_pkg::REG_REGULATION_EN:    reg_en     = csr_pwdata[0];
               wws_pkg::REG_INACTIVITY_EN:    idle_en    = csr_pwdata[0];
               wws_pkg::REG_INACTIVITY_LIMIT: idle_limit = csr_pwdata[19:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(supervise_word(req_word));
         end
      end
      words_outstanding = expected_words.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [2:0] UNUSED_CODE_A     = 3'd5;
   localparam logic [2:0] UNUSED_CODE_B     = 3'd6;
   localparam logic [2:0] UNUSED_CODE_C     = 3'd7;
   localparam int         HOLD_CYCLES       = 300;
   localparam int         DRAIN_CYCLES      = 10;
   localparam int         RANDOM_PHASES     = 8;
   localparam int         PHASE_WORDS       = 200;
   localparam int         MAX_EPISODE_TICKS = 150;
   localparam int         HAUL_TICKS        = 250;
   localparam int         HAUL_KICK_EVERY   = 60;
   localparam int         HAUL_IDLE_LIMIT   = 2000;
   localparam int         TAIL_WORDS        = 40;

   typedef enum int {FLOW_FREE, FLOW_SPARSE, FLOW_PERIODIC, FLOW_HEAVY} flow_kind_type;

   logic                                 clock;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   wws_pkg::wws_req_type                 req_word    = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   wws_pkg::wws_rsp_type                 rsp_word;
   logic                                 csr_psel    = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite  = 1'b0;
   logic [wws_pkg::CSR_ADDR_W-1:0]       csr_paddr   = '0;
   logic [wws_pkg::CSR_DATA_W-1:0]       csr_pwdata  = '0;
   logic [wws_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                 csr_pready;

   int unsigned mismatch_count;
   int unsigned words_outstanding;
   int unsigned burst_left   = 0;
   int unsigned gap_max      = 8;
   int unsigned holds_asked  = 0;
   int unsigned holds_served = 0;
   int unsigned lo_cfg;
   int unsigned hi_cfg;

   windowed_watchdog_supervisor_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wws_response_checker response_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word          (rsp_word),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(64'd60_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      flow_kind_type kind;
      int unsigned   seg_len;
      int unsigned   period_k;
      int unsigned   n;
      forever begin
         if (holds_served != holds_asked) begin
            holds_served++;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            kind     = flow_kind_type'($urandom_range(FLOW_FREE, FLOW_HEAVY));
            seg_len  = $urandom_range(10, 150);
            period_k = $urandom_range(2, 5);
            n        = 0;
            repeat (seg_len) begin
               @(negedge clock);
               case (kind)
                  FLOW_FREE:     rsp_stall <= 1'b0;
                  FLOW_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
                  FLOW_PERIODIC: rsp_stall <= (n % period_k == 0);
                  default:       rsp_stall <= 1'($urandom_range(0, 1));
               endcase
               n++;
            end
         end
      end
   end

   function automatic logic [2:0] rnd3();
      return 3'($urandom);
   endfunction

   function automatic logic rnd1();
      return 1'($urandom);
   endfunction

   function automatic wws_pkg::wws_req_type req_of(input logic [2:0] op,
                                                   input logic [2:0] tgt,
                                                   input logic wmode);
      wws_pkg::wws_req_type w;
      w.operation     = op;
      w.target_state  = tgt;
      w.watchdog_mode = wmode;
      return w;
   endfunction

   task automatic idle_gap(input int unsigned n);
      logic [6:0] noise;
      repeat (n) begin
         @(negedge clock);
         noise = 7'($urandom);
         req_valid <= 1'b0;
         req_word  <= noise;
      end
   endtask

   task automatic send_word(input wws_pkg::wws_req_type w);
      if (burst_left == 0) begin
         idle_gap($urandom_range(0, gap_max));
         burst_left = $urandom_range(1, 40);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_noise();
      logic [6:0] noise;
      noise = 7'($urandom);
      send_word(noise);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (words_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input wws_pkg::wws_reg_type idx,
                            input logic [wws_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_cfg(input int unsigned lo, input int unsigned hi,
                            input int unsigned lim, input int unsigned per,
                            input logic ren, input logic ien, input int unsigned ilim);
      settle();
      csr_write(wws_pkg::REG_WINDOW_LOW, lo);
      csr_write(wws_pkg::REG_WINDOW_HIGH, hi);
      csr_write(wws_pkg::REG_INVALID_LIMIT, lim);
      csr_write(wws_pkg::REG_SECOND_PERIOD, per);
      csr_write(wws_pkg::REG_REGULATION_EN, 32'(ren));
      csr_write(wws_pkg::REG_INACTIVITY_EN, 32'(ien));
      csr_write(wws_pkg::REG_INACTIVITY_LIMIT, ilim);
      lo_cfg = lo;
      hi_cfg = hi;
   endtask

   task automatic run_random(input int unsigned n_words);
      int unsigned sent;
      int unsigned pick;
      int unsigned reps;
      int unsigned span;
      int unsigned k;
      sent = 0;
      holds_asked++;
      while (sent < n_words) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            // well-formed episode: arm, run, kick near the window
            send_word(req_of(wws_pkg::OP_CHANGE,
                             3'($urandom_range(wws_pkg::MODE_RUN, wws_pkg::MODE_LOW)),
                             rnd1()));
            sent++;
            if ($urandom_range(0, 4) != 0) begin
               send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), 1'b1));
               sent++;
            end
            reps = $urandom_range(1, 6);
            repeat (reps) begin
               span = (hi_cfg > lo_cfg) ? (hi_cfg - lo_cfg) / 32'(wws_pkg::TICK_STEP) : 0;
               k = lo_cfg / 32'(wws_pkg::TICK_STEP) + $urandom_range(0, span + 1)
                   + $urandom_range(0, 4);
               k = (k >= 2) ? k - 2 : 0;
               if (k > MAX_EPISODE_TICKS) k = MAX_EPISODE_TICKS;
               repeat (k) send_word(req_of(wws_pkg::OP_TICK, rnd3(), rnd1()));
               send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));
               sent += k + 1;
               if ($urandom_range(0, 2) == 0) begin
                  send_word(req_of(wws_pkg::OP_ACTIVITY, rnd3(), rnd1()));
                  sent++;
               end
            end
         end else begin
            case (pick)
               6: send_noise();
               7: send_word(req_of(wws_pkg::OP_ACTIVITY, rnd3(), rnd1()));
               8: send_word(req_of(wws_pkg::OP_CHANGE, rnd3(), rnd1()));
               default: send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), rnd1()));
            endcase
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned lo;
      int unsigned hi;
      int unsigned lim;
      int unsigned per;
      logic        ien;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      lo_cfg = 32'(wws_pkg::WINDOW_LOW_RESET);
      hi_cfg = 32'(wws_pkg::WINDOW_HIGH_RESET);

      send_word(req_of(wws_pkg::OP_TICK, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));

      // tight window, no tolerance: overrun, persisting excess, valid kick
      write_cfg(0, 20, 0, 30, 1'b1, 1'b1, 32'(wws_pkg::INACT_LIMIT_RESET));
      send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), 1'b1));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_RUN, rnd1()));
      repeat (4) send_word(req_of(wws_pkg::OP_TICK, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_LOW, rnd1()));
      send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), 1'b1));
      send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_TICK, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_DISABLE, rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, UNUSED_CODE_A, rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, UNUSED_CODE_B, rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, UNUSED_CODE_C, rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_WD_DISABLE, rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_IDLE, rnd1()));
      send_word(req_of(UNUSED_CODE_A, rnd3(), rnd1()));
      send_word(req_of(UNUSED_CODE_B, rnd3(), rnd1()));
      send_word(req_of(UNUSED_CODE_C, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_ACTIVITY, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), 1'b0));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_RUN, rnd1()));
      send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));

      write_cfg(0, 0, 0, 10, 1'b0, 1'b0, 0);
      run_random(PHASE_WORDS);
      write_cfg(65535, 65535, 254, 65530, 1'b1, 1'b1, 32'(wws_pkg::INACT_MAX));
      run_random(PHASE_WORDS);

      for (int ph = 2; ph < RANDOM_PHASES; ph++) begin
         lo = $urandom_range(0, 300);
         hi = lo + $urandom_range(0, 100);
         if ($urandom_range(0, 5) == 0) hi = $urandom_range(0, lo);
         lim = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 254);
         if ($urandom_range(0, 3) == 0) begin
            per = 0;
         end else begin
            per = $urandom_range(0, 1) ? $urandom_range(10, 2000)
                                       : $urandom_range(10, 65530);
         end
         ien = 1'($urandom_range(0, 1));
         write_cfg(lo, hi, lim, per, 1'($urandom_range(0, 1)), ien,
                   ien ? $urandom_range(120000, 32'(wws_pkg::INACT_MAX))
                       : $urandom_range(0, 32'(wws_pkg::INACT_MAX)));
         run_random(PHASE_WORDS);
      end

      // long haul: free-running tick counter, inactivity shutdown, halted words
      write_cfg(65000, 65535, 254, 0, 1'b1, 1'b1, HAUL_IDLE_LIMIT);
      gap_max = 2;
      send_word(req_of(wws_pkg::OP_ACTIVITY, rnd3(), rnd1()));
      send_word(req_of(wws_pkg::OP_CHANGE, wws_pkg::MODE_RUN, rnd1()));
      send_word(req_of(wws_pkg::OP_WD_MODE, rnd3(), 1'b1));
      for (int i = 1; i <= HAUL_TICKS; i++) begin
         send_word(req_of(wws_pkg::OP_TICK, rnd3(), rnd1()));
         if (i % HAUL_KICK_EVERY == 0) begin
            send_word(req_of(wws_pkg::OP_KICK, rnd3(), rnd1()));
         end
      end
      repeat (TAIL_WORDS) send_noise();
      settle();

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
